[design/stb_pkg.sv]
// Shared types and constants of the software timer bank.
`default_nettype none
package stb_pkg;

  // Number of timer slots (1 to 16) and the cap on results per tick
  localparam int NUM_TIMERS = 16;
  localparam int MAX_OUT    = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);

  // Operation codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  timer_index;
    logic [23:0] timeout;
    logic        one_shot;
    logic [15:0] elapsed;
  } stb_req_t;

  typedef struct packed {
    logic [3:0] expired_index;
    logic       last;
  } stb_rsp_t;

  // One slot entry as held in the slot memory
  typedef struct packed {
    logic [31:0] deadline;
    logic [23:0] period;
    logic        one_shot;
  } stb_slot_t;

  // Access request from the controller to the slot memory
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    stb_slot_t        wdata;
  } stb_mem_req_t;

endpackage
`default_nettype wire

[design/stb_slot_ram.sv]
// Slot memory: one write port, one read port with registered read data.
`default_nettype none
module stb_slot_ram
  import stb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire stb_mem_req_t req_i,
  output stb_slot_t         rdata_o
);

  stb_slot_t mem_q [NUM_TIMERS];
  stb_slot_t rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/stb_ctrl.sv]
// Controller: clock, enable flags, scan sequencer and result register.
`default_nettype none
module stb_ctrl
  import stb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire stb_req_t     req_i,
  output stb_mem_req_t      mem_req_o,
  input  wire stb_slot_t    mem_rdata_i,
  output logic              result_valid_o,
  output stb_rsp_t          result_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_OUT);

  logic [1:0]            state_q, state_d;
  logic [31:0]           clock_q, clock_d;
  logic [NUM_TIMERS-1:0] en_q, en_d;
  logic [IDX_W-1:0]      chk_q, chk_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  pend_v_q, pend_v_d;
  logic [IDX_W-1:0]      pend_idx_q, pend_idx_d;
  logic                  res_v_q, res_v_d;
  stb_rsp_t              res_q, res_d;

  logic        accept;
  logic        idx_ok;
  logic [31:0] diff;
  logic [31:0] sum;
  logic [31:0] diff2;
  logic        hit;
  logic        behind;

  assign accept = start && (state_q == ST_IDLE);
  assign idx_ok = 32'(req_i.timer_index) < 32'(NUM_TIMERS);
  assign busy   = (state_q != ST_IDLE);

  // Expiry test and periodic reload of the slot under check
  assign diff   = clock_q - mem_rdata_i.deadline;
  assign hit    = en_q[chk_q] && !diff[31] && (cnt_q < CNT_MAX);
  assign sum    = mem_rdata_i.deadline + {8'd0, mem_rdata_i.period};
  assign diff2  = clock_q - sum;
  assign behind = (clock_q != sum) && !diff2[31];

  // Sequence the transactions and the scan
  always_comb begin
    state_d    = state_q;
    clock_d    = clock_q;
    en_d       = en_q;
    chk_d      = chk_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    res_v_d    = 1'b0;
    res_d      = res_q;
    mem_req_o  = '0;
    mem_req_o.wdata = mem_rdata_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.func)
            FUNC_START: begin
              if (idx_ok && (req_i.timeout != 24'd0)) begin
                mem_req_o.we             = 1'b1;
                mem_req_o.waddr          = IDX_W'(req_i.timer_index);
                mem_req_o.wdata.deadline = clock_q + {8'd0, req_i.timeout};
                mem_req_o.wdata.period   = req_i.timeout;
                mem_req_o.wdata.one_shot = req_i.one_shot;
                en_d[IDX_W'(req_i.timer_index)] = 1'b1;
              end
            end
            FUNC_STOP: begin
              if (idx_ok) begin
                en_d[IDX_W'(req_i.timer_index)] = 1'b0;
              end
            end
            FUNC_TICK: begin
              clock_d         = clock_q + {16'd0, req_i.elapsed};
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = '0;
              chk_d           = '0;
              cnt_d           = '0;
              pend_v_d        = 1'b0;
              state_d         = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Fetch the next slot while this one is checked
        if (chk_q != LAST_IDX) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = chk_q + 1'b1;
          chk_d           = chk_q + 1'b1;
        end
        if (hit) begin
          cnt_d = cnt_q + 1'b1;
          if (mem_rdata_i.one_shot) begin
            en_d[chk_q] = 1'b0;
          end else begin
            mem_req_o.we             = 1'b1;
            mem_req_o.waddr          = chk_q;
            mem_req_o.wdata.deadline = behind ? clock_q : sum;
          end
          // Release the held result; the new one waits for a successor
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d.expired_index = 4'(pend_idx_q);
            res_d.last          = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_idx_d = chk_q;
          if (chk_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end
        end else if (chk_q == LAST_IDX) begin
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d.expired_index = 4'(pend_idx_q);
            res_d.last          = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        res_v_d = 1'b1;
        res_d.expired_index = 4'(pend_idx_q);
        res_d.last          = 1'b1;
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      clock_q  <= '0;
      en_q     <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clock_q  <= clock_d;
      en_q     <= en_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    chk_q      <= chk_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule
`default_nettype wire

[design/software_timer_bank.sv]
// Top level of the software timer bank.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; req_i carries func, timer_index, timeout, one_shot, elapsed.
// Start and stop complete in the cycle they are taken and leave busy low.
// A tick advances the millisecond clock and scans every slot, one slot per
// cycle through the slot memory (read, check, write back); busy stays high
// for the whole scan and, when the last slot expires, a flush state after it.
// The next start can be taken only once the scan, and any flush, is over.
// Results: each expired slot appears on result_o for one cycle, marked by
// result_valid_o, in slot order, the final one of a tick with last set.
// A result is held until the next expired slot is found or the scan ends,
// then shown in the following cycle; at most sixteen appear per tick.
// The receiver cannot stall; results must be taken as they come.
// Reset clears the clock and all enable flags; slot memory is not cleared,
// as the contents of disabled slots are never used.
`default_nettype none
module software_timer_bank
  import stb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire stb_req_t req_i,
  output logic          result_valid_o,
  output stb_rsp_t      result_o
);

  stb_mem_req_t mem_req;
  stb_slot_t    mem_rdata;

  stb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  stb_slot_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // A taken tick starts a scan
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.func == FUNC_TICK)) |=> busy)
    else $error("tick transaction did not start a scan");

  // Results come only out of a scan
  a_res_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result outside a scan");

  // Write-back never hits the entry being fetched
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("slot memory read and write to the same entry");

  // Memory is written only when idle or during a scan write-back with busy
  a_start_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && !busy) |-> (start && (req_i.func == FUNC_START)))
    else $error("slot memory written outside a start or scan");

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the software timer bank: queued command driver, result monitor.
`timescale 1ns / 100ps
module tb_top;
  import stb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  // One queued command and the chance that the sender holds off before it
  typedef struct packed {
    stb_req_t   req;
    logic [6:0] idle_pct;
  } feed_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  stb_req_t req_i = '0;
  logic     result_valid_o;
  stb_rsp_t result_o;

  feed_t       command_feed[$];
  stb_rsp_t    expected_expiries[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  // Predicted state of the bank
  logic [31:0] now_ms = '0;
  logic [31:0] slot_deadline[NUM_TIMERS];
  logic [23:0] slot_period[NUM_TIMERS];
  logic        slot_once[NUM_TIMERS];
  logic        slot_armed[NUM_TIMERS];

  software_timer_bank dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    for (int s = 0; s < NUM_TIMERS; s++) begin
      slot_armed[s] = 1'b0;
      slot_deadline[s] = '0;
      slot_period[s] = '0;
      slot_once[s] = 1'b0;
    end
  end

  // Apply one accepted command to the predicted bank and queue the expiries it causes
  task automatic predict_timer_bank(input stb_req_t cmd);
    logic [31:0]          lag;
    logic [NUM_TIMERS-1:0] fired;
    int                   hits;
    int                   final_slot;
    stb_rsp_t             rsp;
    fired = '0;
    hits = 0;
    final_slot = 0;
    case (cmd.func)
      FUNC_START: begin
        if (cmd.timeout != '0 && cmd.timer_index < NUM_TIMERS) begin
          slot_period[cmd.timer_index] = cmd.timeout;
          slot_once[cmd.timer_index] = cmd.one_shot;
          slot_deadline[cmd.timer_index] = now_ms + {8'd0, cmd.timeout};
          slot_armed[cmd.timer_index] = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (cmd.timer_index < NUM_TIMERS) slot_armed[cmd.timer_index] = 1'b0;
      end
      FUNC_TICK: begin
        now_ms = now_ms + {16'd0, cmd.elapsed};
        for (int s = 0; s < NUM_TIMERS; s++) begin
          lag = now_ms - slot_deadline[s];
          if (slot_armed[s] && !lag[31] && hits < MAX_OUT) begin
            if (slot_once[s]) begin
              slot_armed[s] = 1'b0;
            end else begin
              // advance by one period, then pull up to the clock if still behind
              slot_deadline[s] = slot_deadline[s] + {8'd0, slot_period[s]};
              lag = now_ms - slot_deadline[s];
              if (lag != '0 && !lag[31]) slot_deadline[s] = now_ms;
            end
            fired[s] = 1'b1;
            final_slot = s;
            hits++;
          end
        end
        for (int s = 0; s < NUM_TIMERS; s++) begin
          if (fired[s]) begin
            rsp.expired_index = s[3:0];
            rsp.last = (s == final_slot);
            expected_expiries.push_back(rsp);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_command(input logic [1:0] f, input logic [3:0] idx,
                               input logic [23:0] period, input logic once,
                               input logic [15:0] step, input int unsigned pct);
    feed_t item;
    item.req.func = f;
    item.req.timer_index = idx;
    item.req.timeout = period;
    item.req.one_shot = once;
    item.req.elapsed = step;
    item.idle_pct = pct[6:0];
    command_feed.push_back(item);
  endtask

  // Mostly short periods and short steps so that slots keep expiring
  task automatic queue_random_commands(input int unsigned count, input int unsigned pct);
    int unsigned op_roll;
    int unsigned size_roll;
    logic [1:0]  f;
    logic [23:0] period;
    logic [15:0] step;
    for (int unsigned n = 0; n < count; n++) begin
      op_roll = $urandom_range(99);
      size_roll = $urandom_range(99);
      if (op_roll < 40) f = FUNC_START;
      else if (op_roll < 55) f = FUNC_STOP;
      else if (op_roll < 95) f = FUNC_TICK;
      else f = FUNC_UNUSED;
      if (size_roll < 5) period = '0;
      else if (size_roll < 20) period = 24'($urandom);
      else period = 24'($urandom_range(400, 1));
      if ($urandom_range(99) < 25) step = 16'($urandom);
      else step = 16'($urandom_range(200));
      queue_command(f, 4'($urandom_range(15)), period, 1'($urandom_range(1)), step, pct);
    end
  endtask

  // Driver: take accepted transactions into the predictor and present the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_timer_bank(req_i);
      if (!start || !busy) begin
        if (command_feed.size() != 0 && $urandom_range(99) >= command_feed[0].idle_pct) begin
          req_i <= command_feed[0].req;
          start <= 1'b1;
          void'(command_feed.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expected expiry
  always @(posedge clk_i) begin
    stb_rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_expiries.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: slot %0d last %0b", result_o.expired_index,
                   result_o.last);
        mismatches++;
      end else begin
        want = expected_expiries.pop_front();
        if (result_o.expired_index !== want.expired_index || result_o.last !== want.last) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected slot %0d last %0b, got slot %0d last %0b",
                     want.expired_index, want.last, result_o.expired_index, result_o.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // Directed: extremes, ignored commands, pull-up, reload and a full bank
    queue_command(FUNC_TICK, 4'd0, 24'd0, 1'b0, 16'd0, 0);
    queue_command(FUNC_START, 4'd0, 24'd0, 1'b0, 16'd0, 0);
    queue_command(FUNC_UNUSED, 4'hF, 24'hFFFFFF, 1'b1, 16'hFFFF, 0);
    queue_command(FUNC_START, 4'd0, 24'd1, 1'b1, 16'd0, 0);
    queue_command(FUNC_START, 4'd15, 24'hFFFFFF, 1'b0, 16'd0, 0);
    queue_command(FUNC_STOP, 4'd7, 24'd0, 1'b0, 16'd0, 0);
    queue_command(FUNC_TICK, 4'd0, 24'd0, 1'b0, 16'd1, 0);
    queue_command(FUNC_START, 4'd5, 24'd2, 1'b0, 16'd0, 0);
    queue_command(FUNC_TICK, 4'd0, 24'd0, 1'b0, 16'hFFFF, 0);
    queue_command(FUNC_TICK, 4'd0, 24'd0, 1'b0, 16'd0, 0);
    queue_command(FUNC_START, 4'd8, 24'd100, 1'b0, 16'd0, 0);
    queue_command(FUNC_START, 4'd9, 24'd100, 1'b1, 16'd0, 0);
    queue_command(FUNC_TICK, 4'd0, 24'd0, 1'b0, 16'd100, 0);
    for (int s = 0; s < NUM_TIMERS; s++)
      queue_command(FUNC_START, s[3:0], 24'd1, 1'b0, 16'd0, 0);
    queue_command(FUNC_TICK, 4'd0, 24'd0, 1'b0, 16'd5, 0);

    // Random: sender idles a third of the time, then about half, then not at all
    queue_random_commands(150, 33);
    queue_random_commands(150, 48);
    queue_random_commands(150, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all commands taken and every expiry seen, then a quiet stretch
    while (command_feed.size() != 0 || start || expected_expiries.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_expiries.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
